FILE: sv/swm_pkg.sv
package swm_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int SAMPLE_W = 32;
	localparam int WS_W = 7;
	localparam int IDX_W = $clog2(WINDOW_MAX);

	localparam logic [WS_W-1:0] WS_RESET = WS_W'(2);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef struct packed {
		sample_t window_max;
		logic last_of_array;
	} out_item_t;

endpackage

FILE: sv/swm_cell.sv
module swm_cell (
	input  logic              clk,
	input  logic              advance,
	input  swm_pkg::sample_t  sample,
	input  swm_pkg::sample_t  prev_max,
	input  logic              tap,
	output swm_pkg::sample_t  run_max,
	output swm_pkg::sample_t  tap_max
);
	import swm_pkg::*;

	sample_t max_q;
	sample_t max_d;

	assign max_d = (sample >= prev_max) ? sample : prev_max;

	always_ff @(posedge clk) begin
		if (advance) begin
			max_q <= max_d;
		end
	end

	assign run_max = max_q;
	assign tap_max = tap ? max_d : '0;

endmodule

FILE: sv/swm_out_buf.sv
module swm_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  swm_pkg::out_item_t  push_item,
	output logic                full,
	output logic                out_valid,
	input  logic                out_ready,
	output swm_pkg::out_item_t  out_item
);
	import swm_pkg::*;

	logic      main_valid_q;
	logic      skid_valid_q;
	out_item_t main_q;
	out_item_t skid_q;
	logic      pop;

	assign pop = main_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!main_valid_q || pop) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!main_valid_q || pop) begin
				main_q <= push_item;
			end else begin
				skid_q <= push_item;
			end
		end else if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end
	end

	assign full = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_item = main_q;

endmodule

FILE: sv/sliding_window_maximum.sv
// A result is registered in the output buffer on its sample transfer and offered from there.
// One sample per cycle unless input stalls; the running-maximum cells advance on each transfer.
// A two-entry output buffer keeps input open while one result waits; input stalls when both hold.
// Reset clears the fill count and output buffer and sets window_size to 2.
// Cell contents are not cleared; they are read only once a full window of the array has passed.
module sliding_window_maximum (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [swm_pkg::WS_W-1:0]           window_size,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
	input  logic                               starts_array,
	input  logic                               ends_array,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [swm_pkg::SAMPLE_W-1:0] window_max,
	output logic                               last_of_array
);
	import swm_pkg::*;

	logic [WS_W-1:0]  ws_q;
	logic [WS_W-1:0]  k_eff;
	logic [WS_W-1:0]  tap_idx;
	logic [WS_W-1:0]  fill_q;
	logic [WS_W-1:0]  fill_base;
	logic [WS_W-1:0]  fill_next;
	logic             accept;
	logic             produce;
	logic             buf_full;
	sample_t          cell_max [WINDOW_MAX];
	sample_t          cell_tap [WINDOW_MAX];
	sample_t          sel_max;
	out_item_t        push_item;
	out_item_t        out_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ws_q <= window_size;
		end
	end

	always_comb begin
		if (ws_q == '0) begin
			k_eff = WS_W'(1);
		end else if (ws_q > WS_W'(WINDOW_MAX)) begin
			k_eff = WS_W'(WINDOW_MAX);
		end else begin
			k_eff = ws_q;
		end
	end

	assign tap_idx = k_eff - WS_W'(1);

	assign in_ready = !buf_full;
	assign accept = in_valid && in_ready;

	assign fill_base = starts_array ? '0 : fill_q;
	assign fill_next = (fill_base < k_eff) ? fill_base + WS_W'(1) : fill_base;
	assign produce = fill_next >= k_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= ends_array ? '0 : fill_next;
		end
	end

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		swm_cell u_cell (
			.clk      (clk),
			.advance  (accept),
			.sample   (sample),
			.prev_max ((i == 0) ? SAMPLE_MIN : cell_max[(i == 0) ? 0 : i - 1]),
			.tap      (tap_idx[IDX_W-1:0] == IDX_W'(i)),
			.run_max  (cell_max[i]),
			.tap_max  (cell_tap[i])
		);
	end

	always_comb begin
		sel_max = '0;
		for (int j = 0; j < WINDOW_MAX; j++) begin
			sel_max = sel_max | cell_tap[j];
		end
	end

	assign push_item.window_max = sel_max;
	assign push_item.last_of_array = ends_array;

	swm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && produce),
		.push_item (push_item),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	assign window_max = out_item.window_max;
	assign last_of_array = out_item.last_of_array;

	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	a_end_clears_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ends_array) |=> (fill_q == '0))
		else $error("fill count not cleared after array end");

	a_result_offered: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && produce) |=> out_valid)
		else $error("result not offered after transfer");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= WS_W'(WINDOW_MAX))
		else $error("fill count beyond window depth");

endmodule

FILE: tb/sliding_window_maximum_checker.sv
module sliding_window_maximum_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [swm_pkg::WS_W-1:0] window_size,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  swm_pkg::sample_t         sample,
	input  logic                     starts_array,
	input  logic                     ends_array,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  swm_pkg::sample_t         window_max,
	input  logic                     last_of_array,
	output int                       fail_count,
	output int                       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import swm_pkg::*;

	localparam int POS_W = $clog2(2 * WINDOW_MAX);

	logic [WS_W-1:0] window_reg;
	sample_t cand_value[$];
	logic [POS_W-1:0] cand_pos[$];
	logic [POS_W-1:0] next_pos;
	int fill;
	out_item_t expected_maxima[$];
	out_item_t oldest;

	task automatic restart_array();
		cand_value.delete();
		cand_pos.delete();
		next_pos = '0;
		fill = 0;
	endtask

	task automatic slide_window(input sample_t value, input logic opens, input logic closes);
		int span;
		out_item_t due_item;
		span = (window_reg == 0) ? 1 :
			(window_reg > WINDOW_MAX) ? WINDOW_MAX : int'(window_reg);
		if (opens)
			restart_array();
		// drop candidates that have aged out of the window
		while (cand_pos.size() > 0 && POS_W'(next_pos - cand_pos[0]) >= span) begin
			cand_value.delete(0);
			cand_pos.delete(0);
		end
		// drop newer candidates not larger than this sample
		while (cand_value.size() > 0 && value >= cand_value[cand_value.size() - 1]) begin
			cand_value.delete(cand_value.size() - 1);
			cand_pos.delete(cand_pos.size() - 1);
		end
		cand_value = {cand_value, value};
		cand_pos = {cand_pos, next_pos};
		if (fill < span)
			fill++;
		if (fill >= span) begin
			due_item.window_max = cand_value[0];
			due_item.last_of_array = closes;
			expected_maxima = {expected_maxima, due_item};
		end
		next_pos++;
		if (closes)
			restart_array();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_reg = WS_RESET;
			restart_array();
			expected_maxima.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_maxima.size() == 0) begin
					$display("%0t: result with none expected: window_max %0d last_of_array %0b",
						$time, window_max, last_of_array);
					fail_count++;
				end else begin
					oldest = expected_maxima[0];
					expected_maxima.delete(0);
					if (window_max !== oldest.window_max) begin
						$display("%0t: window_max expected %0d actual %0d",
							$time, oldest.window_max, window_max);
						fail_count++;
					end
					if (last_of_array !== oldest.last_of_array) begin
						$display("%0t: last_of_array expected %0b actual %0b",
							$time, oldest.last_of_array, last_of_array);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				slide_window(sample, starts_array, ends_array);
			if (cfg_valid && cfg_ready)
				window_reg = window_size;
			outstanding <= expected_maxima.size();
		end
	end

endmodule

FILE: tb/sliding_window_maximum_tb.sv
module sliding_window_maximum_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swm_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_TARGET = 530;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [WS_W-1:0] window_size = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	sample_t sample = '0;
	logic starts_array = 1'b0;
	logic ends_array = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	sample_t window_max;
	logic last_of_array;
	int fail_count;
	int outstanding;
	int idle_cycles = 0;
	int sent = 0;
	bit steady = 1'b0;
	bit hold_output = 1'b0;

	always #5 clk = ~clk;

	sliding_window_maximum dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.window_size   (window_size),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.starts_array  (starts_array),
		.ends_array    (ends_array),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.window_max    (window_max),
		.last_of_array (last_of_array)
	);

	sliding_window_maximum_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.window_size   (window_size),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.starts_array  (starts_array),
		.ends_array    (ends_array),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.window_max    (window_max),
		.last_of_array (last_of_array),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	task automatic write_window(input logic [WS_W-1:0] value);
		cfg_valid <= 1'b1;
		window_size <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input sample_t value, input logic opens, input logic closes);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		starts_array <= opens;
		ends_array <= closes;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (3) @(posedge clk);
	endtask

	function automatic sample_t random_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MIN;
			1: return ~SAMPLE_MIN;
			2, 3, 4: return sample_t'(int'($urandom_range(0, 6)) - 3);
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_array(input int len, input bit with_start, input bit with_end);
		for (int i = 0; i < len; i++)
			send_sample(random_sample(),
				(i == 0) ? with_start : ($urandom_range(0, 49) == 0),
				(i == len - 1) && with_end);
	endtask

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else begin
				stall = steady ? 0 : $urandom_range(0, 7);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sliding_window_maximum: mismatch");
			$finish;
		end
	end

	initial begin
		int span;
		int kind;
		int len;
		int phase_start;
		logic [WS_W-1:0] setting;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(~SAMPLE_MIN, 1'b1, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0, 1'b0);
		send_sample(sample_t'(0), 1'b0, 1'b0);
		send_sample(sample_t'(-1), 1'b0, 1'b1);
		send_sample(sample_t'(5), 1'b1, 1'b1);
		send_sample(sample_t'(7), 1'b0, 1'b0);
		send_sample(sample_t'(7), 1'b0, 1'b1);
		send_sample(sample_t'(3), 1'b1, 1'b0);
		send_sample(sample_t'(1), 1'b0, 1'b1);
		settle();
		write_window('0);
		send_sample(sample_t'(42), 1'b1, 1'b1);
		send_sample(sample_t'(-5), 1'b1, 1'b0);
		send_sample(sample_t'(9), 1'b0, 1'b0);
		send_sample(sample_t'(9), 1'b0, 1'b1);
		settle();
		write_window('1);
		send_sample(sample_t'(100), 1'b1, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0, 1'b0);
		send_sample(~SAMPLE_MIN, 1'b0, 1'b1);
		settle();
		write_window(WS_W'(3));
		send_sample(sample_t'(1), 1'b1, 1'b0);
		send_sample(sample_t'(5), 1'b0, 1'b0);
		send_sample(sample_t'(2), 1'b0, 1'b0);
		send_sample(sample_t'(2), 1'b0, 1'b0);
		send_sample(sample_t'(0), 1'b0, 1'b1);
		send_sample(sample_t'(10), 1'b1, 1'b0);
		send_sample(sample_t'(20), 1'b0, 1'b0);
		settle();
		write_window(WS_W'(2));
		send_sample(sample_t'(1), 1'b0, 1'b1);

		// hold the output so the block fills and stalls its input
		settle();
		steady = 1'b1;
		hold_output = 1'b1;
		send_array(40, 1'b1, 1'b1);
		steady = 1'b0;

		for (int phase = 0; sent < ITEM_TARGET; phase++) begin
			case (phase)
				0: setting = WS_W'(1);
				1: setting = WS_W'(WINDOW_MAX);
				2: setting = '1;
				3: setting = '0;
				4: setting = WS_W'(WINDOW_MAX + 1);
				default: setting = ($urandom_range(0, 3) == 0) ?
					WS_W'($urandom_range(0, 127)) : WS_W'($urandom_range(1, 8));
			endcase
			settle();
			write_window(setting);
			span = (setting == 0) ? 1 : (setting > WINDOW_MAX) ? WINDOW_MAX : int'(setting);
			phase_start = sent;
			while (sent - phase_start < 50) begin
				steady = ($urandom_range(0, 4) == 0);
				kind = $urandom_range(0, 29);
				len = $urandom_range((span > 3) ? span - 3 : 1, span + 12);
				case (kind)
					0: send_array($urandom_range(130, 180), 1'b1, 1'b1);
					1, 2: send_array($urandom_range(1, span), 1'b1, 1'b1);
					3, 4: send_array(len, 1'b0, 1'b1);
					5, 6: send_array(len, 1'b1, 1'b0);
					default: send_array(len, 1'b1, 1'b1);
				endcase
			end
		end

		steady = 1'b0;
		settle();
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("sliding_window_maximum: match");
		else
			$display("sliding_window_maximum: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
sv/swm_pkg.sv
sv/swm_cell.sv
sv/swm_out_buf.sv
sv/sliding_window_maximum.sv
tb/sliding_window_maximum_checker.sv
tb/sliding_window_maximum_tb.sv
